### rtl/rkf_pkg.sv
// ----------------------------------------------------------------------------
// rkf_pkg: shared types and constants of the raster kernel filter
// Sizes, register indexes, filter modes, kernel weights and the structs that
// travel between the front end, the queue and the filter back end.
// ----------------------------------------------------------------------------
package rkf_pkg;

  // Image limits and derived widths
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int WID_W      = COL_W + 1;
  localparam int HGT_W      = ROW_W + 1;
  localparam int PIX_W      = 8;
  localparam int BAND_W     = 8;
  localparam int LANES      = 4;
  localparam int LANE_W     = $clog2(LANES);

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Gaussian weights by ring, normalization by reciprocal multiply
  localparam int GAUSS_W4    = 4;
  localparam int GAUSS_W7    = 7;
  localparam int GAUSS_W16   = 16;
  localparam int GAUSS_W26   = 26;
  localparam int GAUSS_W41   = 41;
  localparam int GAUSS_NORM  = 273;
  localparam int GAUSS_SHIFT = 25;
  localparam int GAUSS_RECIP = (2 ** GAUSS_SHIFT + GAUSS_NORM - 1) / GAUSS_NORM;
  localparam int GSUM_W      = 17;
  localparam int PROD_W      = 34;

  // 3x3 kernels
  localparam int S3_W           = 13;
  localparam int RELIEF_BIAS    = 125;
  localparam int SHARPEN_CENTER = 9;

  typedef enum logic [1:0] {
    MODE_GAUSS   = 2'd0,
    MODE_EMBOSS  = 2'd1,
    MODE_RELIEF  = 2'd2,
    MODE_SHARPEN = 2'd3
  } rkf_mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FILTER_MODE  = 2'd0,
    CFG_IMAGE_WIDTH  = 2'd1,
    CFG_IMAGE_HEIGHT = 2'd2,
    CFG_BAND_COUNT   = 2'd3
  } rkf_cfg_idx_t;

  // Effective configuration seen by the front end
  typedef struct packed {
    rkf_mode_t         mode;
    logic [WID_W-1:0]  width;
    logic [HGT_W-1:0]  height;
    logic [BAND_W-1:0] bands;
  } rkf_cfg_t;

  // Classification of one item
  typedef struct packed {
    logic              emit;
    rkf_mode_t         mode;
    logic [BAND_W-1:0] band;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  column;
    logic              done;
  } rkf_meta_t;

  // Queue entry: one new window column plus its tags
  typedef struct packed {
    logic [4:0][PIX_W-1:0] pix;
    rkf_meta_t             meta;
  } rkf_qent_t;

endpackage

### rtl/rkf_if.sv
// ----------------------------------------------------------------------------
// rkf_if: channel interfaces of the raster kernel filter
// Pixel input channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------
interface rkf_pix_if
  import rkf_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_value;

  modport source (output valid, output pixel_value, input ready);
  modport sink (input valid, input pixel_value, output ready);
endinterface

interface rkf_res_if
  import rkf_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [PIX_W-1:0]  filtered_value;
  logic [BAND_W-1:0] out_band;
  logic [ROW_W-1:0]  out_row;
  logic [COL_W-1:0]  out_column;
  logic              band_done;

  modport source (output valid, output filtered_value, output out_band, output out_row,
                  output out_column, output band_done, input ready);
  modport sink (input valid, input filtered_value, input out_band, input out_row,
                input out_column, input band_done, output ready);
endinterface

interface rkf_cfg_if
  import rkf_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/rkf_front.sv
// ----------------------------------------------------------------------------
// rkf_front: pixel intake, line store and classification
// Tracks band, row and column, keeps the last four lines in a column-wide
// memory, tags each item with its output position and hands the new window
// column to the queue.
// ----------------------------------------------------------------------------
module rkf_front
  import rkf_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  rkf_pix_if.sink       in_ch,
  input  rkf_cfg_t      cfg,
  input  logic          q_full,
  output logic          q_push,
  output rkf_qent_t     q_wdata
);

  logic [COL_W-1:0]  col_r;
  logic [ROW_W-1:0]  row_r;
  logic [BAND_W-1:0] band_r;

  logic [LANES-1:0][PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [LANES-1:0][PIX_W-1:0] rd_r;

  logic              f1_valid_r;
  logic [PIX_W-1:0]  f1_pix_r;
  logic [LANE_W-1:0] f1_lane_r;
  rkf_meta_t         f1_meta_r;

  logic              accept;
  rkf_meta_t         meta_nxt;
  logic              in_img;
  logic              core;
  logic [ROW_W-1:0]  cr;
  logic [COL_W-1:0]  cc;
  logic [HGT_W-1:0]  last_r;
  logic [WID_W-1:0]  last_c;
  logic [WID_W-1:0]  col_inc;
  logic [HGT_W-1:0]  row_inc;
  logic [BAND_W:0]   band_inc;

  // Handshake: the intake register frees up whenever the queue takes its item
  always_comb begin
    q_push      = f1_valid_r && !q_full;
    in_ch.ready = !f1_valid_r || !q_full;
    accept      = in_ch.valid && in_ch.ready;
  end

  // Classify the current position
  always_comb begin
    in_img = ({1'b0, row_r} < cfg.height) && ({1'b0, col_r} < cfg.width);
    if (cfg.mode == MODE_SHARPEN) begin
      core   = (row_r >= ROW_W'(2)) && (col_r >= COL_W'(2));
      cr     = row_r - ROW_W'(1);
      cc     = col_r - COL_W'(1);
      last_r = cfg.height - HGT_W'(2);
      last_c = cfg.width - WID_W'(2);
    end else begin
      core   = (row_r >= ROW_W'(4)) && (col_r >= COL_W'(4));
      cr     = row_r - ROW_W'(2);
      cc     = col_r - COL_W'(2);
      last_r = cfg.height - HGT_W'(3);
      last_c = cfg.width - WID_W'(3);
    end
    meta_nxt.emit   = in_img && core;
    meta_nxt.mode   = cfg.mode;
    meta_nxt.band   = band_r;
    meta_nxt.row    = cr;
    meta_nxt.column = cc;
    meta_nxt.done   = in_img && core && ({1'b0, cr} == last_r) && ({1'b0, cc} == last_c);
  end

  // Position counters with wrap to next line and next band
  always_comb begin
    col_inc  = {1'b0, col_r} + WID_W'(1);
    row_inc  = {1'b0, row_r} + HGT_W'(1);
    band_inc = {1'b0, band_r} + (BAND_W + 1)'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      band_r <= '0;
    end else if (accept) begin
      if (col_inc >= cfg.width) begin
        col_r <= '0;
        if (row_inc >= cfg.height) begin
          row_r <= '0;
          if (band_inc >= {1'b0, cfg.bands}) begin
            band_r <= '0;
          end else begin
            band_r <= band_inc[BAND_W-1:0];
          end
        end else begin
          row_r <= row_inc[ROW_W-1:0];
        end
      end else begin
        col_r <= col_inc[COL_W-1:0];
      end
    end
  end

  // Line store: read the column's four lines, overwrite the oldest one
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_r                              <= line_mem[col_r];
      line_mem[col_r][row_r[LANE_W-1:0]] <= in_ch.pixel_value;
    end
  end

  // Intake register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_valid_r <= 1'b0;
    end else if (accept) begin
      f1_valid_r <= 1'b1;
    end else if (q_push) begin
      f1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f1_pix_r  <= in_ch.pixel_value;
      f1_lane_r <= row_r[LANE_W-1:0];
      f1_meta_r <= meta_nxt;
    end
  end

  // Order the column oldest line first, new pixel last
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      q_wdata.pix[i] = rd_r[LANE_W'(f1_lane_r + LANE_W'(i))];
    end
    q_wdata.pix[4] = f1_pix_r;
    q_wdata.meta   = f1_meta_r;
  end

`ifndef SYNTH
  a_done_needs_emit: assert property (@(posedge clk) disable iff (!rst_n)
    f1_valid_r && f1_meta_r.done |-> f1_meta_r.emit)
    else $error("band_done tag on an item that gives no result");
`endif

endmodule

### rtl/rkf_queue.sv
// ----------------------------------------------------------------------------
// rkf_queue: short item queue between front end and filter back end
// Register-based FIFO with a combinational head.
// ----------------------------------------------------------------------------
module rkf_queue
  import rkf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  rkf_qent_t wdata,
  output logic      full,
  input  logic      pop,
  output rkf_qent_t rdata,
  output logic      empty
);

  rkf_qent_t          mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r;
  logic [QPTR_W-1:0]  rd_ptr_r;
  logic [QCNT_W-1:0]  count_r;

  always_comb begin
    full  = (count_r == QCNT_W'(QUEUE_DEPTH));
    empty = (count_r == '0);
    rdata = mem_r[rd_ptr_r];
  end

  // Store the item
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   count_r <= count_r + QCNT_W'(1);
        2'b01:   count_r <= count_r - QCNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
    else $error("queue read while empty");
`endif

endmodule

### rtl/rkf_back.sv
// ----------------------------------------------------------------------------
// rkf_back: 5x5 window and filter datapath
// Shifts each queued column into the window, then sums the kernel over four
// stages (ring sums, weighted sum, reciprocal multiply, saturate) into the
// output register. The whole pipe holds while the output is stalled.
// ----------------------------------------------------------------------------
module rkf_back
  import rkf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_empty,
  input  rkf_qent_t q_rdata,
  output logic      q_pop,
  rkf_res_if.source out_ch
);

  logic [4:0][4:0][PIX_W-1:0] win_r;

  logic adv;

  logic      a_valid_r;
  rkf_meta_t a_meta_r;

  logic                   b_valid_r;
  rkf_meta_t              b_meta_r;
  logic [9:0]             b_s1_r;
  logic [10:0]            b_s4_r;
  logic [9:0]             b_s7_r;
  logic [9:0]             b_s16_r;
  logic [9:0]             b_s26_r;
  logic [PIX_W-1:0]       b_s41_r;
  logic signed [S3_W-1:0] b_s3_r;

  logic                   c_valid_r;
  rkf_meta_t              c_meta_r;
  logic [GSUM_W-1:0]      c_gauss_r;
  logic signed [S3_W-1:0] c_s3_r;

  logic                   d_valid_r;
  rkf_meta_t              d_meta_r;
  logic [PROD_W-1:0]      d_prod_r;
  logic signed [S3_W-1:0] d_s3_r;

  logic              out_valid_r;
  logic [PIX_W-1:0]  out_value_r;
  logic [BAND_W-1:0] out_band_r;
  logic [ROW_W-1:0]  out_row_r;
  logic [COL_W-1:0]  out_col_r;
  logic              out_done_r;

  logic signed [S3_W-1:0] p [5][5];
  logic signed [S3_W-1:0] s3_nxt;
  logic [PIX_W-1:0]       value_nxt;

  // Hold everything while a result waits
  always_comb begin
    adv   = !out_valid_r || out_ch.ready;
    q_pop = adv && !q_empty;
  end

  // Window shift
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (q_pop) begin
      for (int i = 0; i < 5; i++) begin
        for (int j = 0; j < 4; j++) begin
          win_r[i][j] <= win_r[i][j+1];
        end
        win_r[i][4] <= q_rdata.pix[i];
      end
    end
  end

  // Signed view of the window for the 3x3 kernels
  always_comb begin
    for (int i = 0; i < 5; i++) begin
      for (int j = 0; j < 5; j++) begin
        p[i][j] = $signed(S3_W'(win_r[i][j]));
      end
    end
    unique case (a_meta_r.mode)
      MODE_EMBOSS:
        s3_nxt = p[2][3] + p[3][2] + p[3][3] - p[1][1] - p[1][2] - p[2][1];
      MODE_RELIEF:
        s3_nxt = (p[1][1] <<< 1) - p[2][2] - p[3][3] + S3_W'(RELIEF_BIAS);
      MODE_SHARPEN:
        s3_nxt = p[3][3] * S3_W'(SHARPEN_CENTER)
               - p[2][2] - p[2][3] - p[2][4] - p[3][2]
               - p[3][4] - p[4][2] - p[4][3] - p[4][4];
      default:
        s3_nxt = '0;
    endcase
  end

  // Valid bits of the datapath stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      c_valid_r   <= 1'b0;
      d_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      a_valid_r   <= q_pop;
      b_valid_r   <= a_valid_r && a_meta_r.emit;
      c_valid_r   <= b_valid_r;
      d_valid_r   <= c_valid_r;
      out_valid_r <= d_valid_r;
    end
  end

  // Saturate to a pixel
  always_comb begin
    if (d_meta_r.mode == MODE_GAUSS) begin
      value_nxt = d_prod_r[GAUSS_SHIFT +: PIX_W];
    end else if (d_s3_r < 0) begin
      value_nxt = '0;
    end else if (d_s3_r > S3_W'(255)) begin
      value_nxt = '1;
    end else begin
      value_nxt = d_s3_r[PIX_W-1:0];
    end
  end

  // Datapath stages
  always_ff @(posedge clk) begin
    if (adv) begin
      if (q_pop) begin
        a_meta_r <= q_rdata.meta;
      end
      // Ring sums of the Gaussian and the 3x3 sum
      b_meta_r <= a_meta_r;
      b_s1_r   <= 10'(win_r[0][0]) + 10'(win_r[0][4]) + 10'(win_r[4][0]) + 10'(win_r[4][4]);
      b_s4_r   <= 11'(win_r[0][1]) + 11'(win_r[0][3]) + 11'(win_r[1][0]) + 11'(win_r[1][4])
                + 11'(win_r[3][0]) + 11'(win_r[3][4]) + 11'(win_r[4][1]) + 11'(win_r[4][3]);
      b_s7_r   <= 10'(win_r[0][2]) + 10'(win_r[2][0]) + 10'(win_r[2][4]) + 10'(win_r[4][2]);
      b_s16_r  <= 10'(win_r[1][1]) + 10'(win_r[1][3]) + 10'(win_r[3][1]) + 10'(win_r[3][3]);
      b_s26_r  <= 10'(win_r[1][2]) + 10'(win_r[2][1]) + 10'(win_r[2][3]) + 10'(win_r[3][2]);
      b_s41_r  <= win_r[2][2];
      b_s3_r   <= s3_nxt;
      // Weighted Gaussian sum
      c_meta_r  <= b_meta_r;
      c_gauss_r <= GSUM_W'(b_s1_r)
                 + GSUM_W'(b_s4_r) * GSUM_W'(GAUSS_W4)
                 + GSUM_W'(b_s7_r) * GSUM_W'(GAUSS_W7)
                 + GSUM_W'(b_s16_r) * GSUM_W'(GAUSS_W16)
                 + GSUM_W'(b_s26_r) * GSUM_W'(GAUSS_W26)
                 + GSUM_W'(b_s41_r) * GSUM_W'(GAUSS_W41);
      c_s3_r    <= b_s3_r;
      // Divide by the normalization through its reciprocal
      d_meta_r <= c_meta_r;
      d_prod_r <= PROD_W'(c_gauss_r) * PROD_W'(GAUSS_RECIP);
      d_s3_r   <= c_s3_r;
      // Output register
      out_value_r <= value_nxt;
      out_band_r  <= d_meta_r.band;
      out_row_r   <= d_meta_r.row;
      out_col_r   <= d_meta_r.column;
      out_done_r  <= d_meta_r.done;
    end
  end

  always_comb begin
    out_ch.valid          = out_valid_r;
    out_ch.filtered_value = out_value_r;
    out_ch.out_band       = out_band_r;
    out_ch.out_row        = out_row_r;
    out_ch.out_column     = out_col_r;
    out_ch.band_done      = out_done_r;
  end

`ifndef SYNTH
  a_gauss_fits: assert property (@(posedge clk) disable iff (!rst_n)
    d_valid_r && (d_meta_r.mode == MODE_GAUSS) |-> (d_prod_r[PROD_W-1:GAUSS_SHIFT+PIX_W] == '0))
    else $error("gaussian quotient exceeds a pixel");
`endif

endmodule

### rtl/raster_kernel_filter_top.sv
// ----------------------------------------------------------------------------
// raster_kernel_filter_top: streaming 3x3 / 5x5 image filter
// Configuration registers, front end, item queue and filter back end.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  takes raw 8-bit pixels in raster order, band after band.
//   out_ch gives one filtered pixel per interior window center, tagged with
//          band, row and column; band_done marks the last one of a band.
//   cfg_ch writes filter_mode (0), image_width (1), image_height (2) and
//          band_count (3); it is always ready. Write it only while idle.
// Throughput: one pixel per clock while out_ch is ready, set by the
//   single-port line store that is read and written once per accepted pixel.
// Path: the pixel that completes a window passes the intake register, the
//   queue, the window, three arithmetic stages and the output register on
//   its way to out_ch.
// Reset: position counters go to zero, registers to mode 0, 640 x 480,
//   one band; the queue and the pipeline empty. Line store contents are not
//   cleared: they only reach window positions of border pixels.
// Stall: when out_ch is not ready the back end holds; the queue and intake
//   register absorb five more pixels before in_ch.ready drops.
// ----------------------------------------------------------------------------
module raster_kernel_filter_top
  import rkf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  rkf_pix_if.sink   in_ch,
  rkf_res_if.source out_ch,
  rkf_cfg_if.sink   cfg_ch
);

  rkf_mode_t         mode_r;
  logic [WID_W-1:0]  width_r;
  logic [HGT_W-1:0]  height_r;
  logic [BAND_W-1:0] bands_r;

  rkf_cfg_t  cfg;
  logic      q_push;
  logic      q_pop;
  logic      q_full;
  logic      q_empty;
  rkf_qent_t q_wdata;
  rkf_qent_t q_rdata;

  assign cfg_ch.ready = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_GAUSS;
      width_r  <= WID_W'(640);
      height_r <= HGT_W'(480);
      bands_r  <= BAND_W'(1);
    end else if (cfg_ch.valid) begin
      unique case (rkf_cfg_idx_t'(cfg_ch.index))
        CFG_FILTER_MODE:  mode_r   <= rkf_mode_t'(cfg_ch.data[1:0]);
        CFG_IMAGE_WIDTH:  width_r  <= cfg_ch.data[WID_W-1:0];
        CFG_IMAGE_HEIGHT: height_r <= cfg_ch.data[HGT_W-1:0];
        CFG_BAND_COUNT:   bands_r  <= cfg_ch.data[BAND_W-1:0];
      endcase
    end
  end

  // Clamp width to the line store and height to the row counter, and treat zero as one
  always_comb begin
    cfg.mode = mode_r;
    if (width_r > WID_W'(MAX_WIDTH)) begin
      cfg.width = WID_W'(MAX_WIDTH);
    end else if (width_r == '0) begin
      cfg.width = WID_W'(1);
    end else begin
      cfg.width = width_r;
    end
    if (height_r > HGT_W'(MAX_HEIGHT)) begin
      cfg.height = HGT_W'(MAX_HEIGHT);
    end else if (height_r == '0) begin
      cfg.height = HGT_W'(1);
    end else begin
      cfg.height = height_r;
    end
    cfg.bands = (bands_r == '0) ? BAND_W'(1) : bands_r;
  end

  rkf_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .cfg     (cfg),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_wdata (q_wdata)
  );

  rkf_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  rkf_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_rdata (q_rdata),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

### tb/tb_raster_kernel_filter_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_raster_kernel_filter_top: self-checking bench of the raster kernel filter
// Streams pixel frames under a range of filter settings and predicts every
// filtered pixel with a behavioral copy of the line stores and the 5x5 window.
// Each result is matched field by field against the oldest prediction, while
// random gaps on the pixel side and random stalls on the result side move the
// timing around.
// ----------------------------------------------------------------------------
module tb_raster_kernel_filter_top;
  import rkf_pkg::*;

  localparam int IDLE_LIMIT    = 2000;
  localparam int SETTLE_CYCLES = 32;
  localparam int RANDOM_ITEMS  = 280;
  localparam int CALM_ITEMS    = 120;

  localparam int GAUSS_K [25] = '{
    1,  4,  7,  4, 1,
    4, 16, 26, 16, 4,
    7, 26, 41, 26, 7,
    4, 16, 26, 16, 4,
    1,  4,  7,  4, 1
  };
  localparam int EMBOSS_K  [9] = '{-1, -1, 0, -1, 0, 1, 0, 1, 1};
  localparam int RELIEF_K  [9] = '{2, 0, 0, 0, -1, 0, 0, 0, -1};
  localparam int SHARPEN_K [9] = '{-1, -1, -1, -1, SHARPEN_CENTER, -1, -1, -1, -1};

  typedef enum int {
    PAT_UNIFORM,
    PAT_EXTREME,
    PAT_MID,
    PAT_BITS
  } pix_pattern_t;

  typedef struct packed {
    logic [PIX_W-1:0]  value;
    logic [BAND_W-1:0] band;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  column;
    logic              done;
  } filt_pix_t;

  // Filter predictor and queue of pending filtered pixels
  class filter_scoreboard;
    rkf_mode_t        mode;
    int unsigned      width;
    int unsigned      height;
    int unsigned      bands;
    logic [PIX_W-1:0] line_mem [LANES*MAX_WIDTH];
    logic [PIX_W-1:0] win [25];
    int unsigned      col_pos;
    int unsigned      row_pos;
    int unsigned      band_pos;
    filt_pix_t        expected_pixels [$];
    int unsigned      errors;
    int unsigned      pixels;
    int unsigned      results;

    function new();
      mode     = MODE_GAUSS;
      width    = 640;
      height   = 480;
      bands    = 1;
      col_pos  = 0;
      row_pos  = 0;
      band_pos = 0;
      errors   = 0;
      pixels   = 0;
      results  = 0;
      foreach (line_mem[i]) line_mem[i] = '0;
      foreach (win[i]) win[i] = '0;
    endfunction

    function void write_reg(rkf_cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_FILTER_MODE:  mode   = rkf_mode_t'(data[1:0]);
        CFG_IMAGE_WIDTH:  width  = data[WID_W-1:0];
        CFG_IMAGE_HEIGHT: height = data[HGT_W-1:0];
        CFG_BAND_COUNT:   bands  = data[BAND_W-1:0];
        default: ;
      endcase
    endfunction

    // Sizes as the block sees them: clamp to the maxima, zero counts as one
    function int unsigned eff_width();
      if (width > MAX_WIDTH) return MAX_WIDTH;
      return (width == 0) ? 1 : width;
    endfunction

    function int unsigned eff_height();
      if (height > MAX_HEIGHT) return MAX_HEIGHT;
      return (height == 0) ? 1 : height;
    endfunction

    function int unsigned eff_bands();
      return (bands == 0) ? 1 : bands;
    endfunction

    function int unsigned frame_items();
      return eff_width() * eff_height() * eff_bands();
    endfunction

    function bit at_origin();
      return (col_pos == 0) && (row_pos == 0) && (band_pos == 0);
    endfunction

    // 3x3 sum with its top-left corner at window position (r0, c0)
    function int sum3(int k [9], int unsigned r0, int unsigned c0);
      int s;
      s = 0;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          s += int'(win[(r0 + i) * 5 + c0 + j]) * k[i * 3 + j];
      return s;
    endfunction

    // Advance the window by one pixel and queue the filtered pixel it yields
    function void note_pixel(logic [PIX_W-1:0] pix);
      int unsigned      w, h, b, r, c, ci, cr, cc, last_r, last_c;
      int               s;
      bit               emit;
      logic [PIX_W-1:0] col [5];
      filt_pix_t        want;
      w      = eff_width();
      h      = eff_height();
      b      = eff_bands();
      r      = row_pos;
      c      = col_pos;
      ci     = c % MAX_WIDTH;
      s      = 0;
      emit   = 0;
      cr     = 0;
      cc     = 0;
      last_r = 0;
      last_c = 0;
      pixels++;

      for (int i = 0; i < 4; i++) col[i] = line_mem[((r + i) & 3) * MAX_WIDTH + ci];
      col[4] = pix;
      line_mem[(r & 3) * MAX_WIDTH + ci] = pix;
      for (int i = 0; i < 5; i++) begin
        for (int j = 0; j < 4; j++) win[i * 5 + j] = win[i * 5 + j + 1];
        win[i * 5 + 4] = col[i];
      end

      if (r < h && c < w) begin
        if (mode == MODE_SHARPEN) begin
          if (r >= 2 && c >= 2) begin
            cr     = r - 1;
            cc     = c - 1;
            last_r = h - 2;
            last_c = w - 2;
            s      = sum3(SHARPEN_K, 2, 2);
            emit   = 1;
          end
        end else if (r >= 4 && c >= 4) begin
          cr     = r - 2;
          cc     = c - 2;
          last_r = h - 3;
          last_c = w - 3;
          case (mode)
            MODE_GAUSS: begin
              for (int i = 0; i < 25; i++) s += int'(win[i]) * GAUSS_K[i];
              s = s / GAUSS_NORM;
            end
            MODE_EMBOSS: s = sum3(EMBOSS_K, 1, 1);
            default:     s = sum3(RELIEF_K, 1, 1) + RELIEF_BIAS;
          endcase
          emit = 1;
        end
        if (emit) begin
          want.value  = (s < 0) ? 8'd0 : (s > 255) ? 8'd255 : s[PIX_W-1:0];
          want.band   = band_pos[BAND_W-1:0];
          want.row    = cr[ROW_W-1:0];
          want.column = cc[COL_W-1:0];
          want.done   = (cr == last_r) && (cc == last_c);
          expected_pixels.push_back(want);
        end
      end

      // Step the raster position; wrap to the next line, band and frame
      col_pos = c + 1;
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos = r + 1;
        if (row_pos >= h) begin
          row_pos = 0;
          band_pos++;
          if (band_pos >= b) band_pos = 0;
        end
      end
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_pixel(filt_pix_t got);
      filt_pix_t want;
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual value %0d band %0d row %0d col %0d",
                 $time, got.value, got.band, got.row, got.column);
        errors++;
        return;
      end
      want = expected_pixels.pop_front();
      results++;
      compare_field("filtered_value", want.value, got.value);
      compare_field("out_band", want.band, got.band);
      compare_field("out_row", want.row, got.row);
      compare_field("out_column", want.column, got.column);
      compare_field("band_done", want.done, got.done);
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  bit          in_idle_en;
  bit          out_stall_en;
  int unsigned idle_cycles;
  int unsigned settings_run;

  filter_scoreboard sb = new();

  rkf_pix_if in_ch ();
  rkf_res_if out_ch ();
  rkf_cfg_if cfg_ch ();

  raster_kernel_filter_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Result side: hold ready low in random bursts while stalls are enabled
  initial begin
    out_ch.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (out_stall_en && $urandom_range(0, 9) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Check every accepted result item
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_pixel({out_ch.filtered_value, out_ch.out_band, out_ch.out_row,
                      out_ch.out_column, out_ch.band_done});
  end

  // Watchdog: end the run after too long without any accepted item
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no item accepted for %0d cycles", $time, IDLE_LIMIT);
      $display("raster_kernel_filter_top regression: fail");
      $finish;
    end
  end

  function automatic logic [PIX_W-1:0] gen_pixel(pix_pattern_t pat);
    case (pat)
      PAT_UNIFORM: return PIX_W'($urandom_range(0, 255));
      PAT_EXTREME: return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
      PAT_MID:     return PIX_W'($urandom_range(96, 160));
      default:     return ($urandom_range(0, 1) != 0) ? (8'h01 << $urandom_range(0, 7))
                                                      : ~(8'h01 << $urandom_range(0, 7));
    endcase
  endfunction

  // Offer one pixel item, with an optional gap before it, and hold until taken
  task automatic send_pixel(input logic [PIX_W-1:0] pix);
    if (in_idle_en && $urandom_range(0, 7) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.pixel_value <= pix;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_pixel(pix);
  endtask

  // Drop valid, wait for every pending result, then let the pipeline settle
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (sb.expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input rkf_cfg_idx_t idx, input int unsigned value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value[CFG_DATA_W-1:0];
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    sb.write_reg(idx, value[CFG_DATA_W-1:0]);
  endtask

  task automatic program_filter(input rkf_mode_t m, input int unsigned w,
                                input int unsigned h, input int unsigned b);
    write_reg(CFG_FILTER_MODE, m);
    write_reg(CFG_IMAGE_WIDTH, w);
    write_reg(CFG_IMAGE_HEIGHT, h);
    write_reg(CFG_BAND_COUNT, b);
    cfg_ch.valid <= 1'b0;
    settings_run++;
  endtask

  // Stream whole frames of all bands; optionally pause mid-frame until drained
  task automatic run_frames(input pix_pattern_t pat, input bit pause);
    int unsigned n;
    int unsigned stop_at;
    n       = sb.frame_items();
    stop_at = (pause && n > 1) ? $urandom_range(1, n - 1) : n;
    for (int unsigned k = 0; k < n; k++) begin
      if (k == stop_at) wait_drained();
      send_pixel(gen_pixel(pat));
    end
    wait_drained();
  endtask

  initial begin
    int unsigned  rand_items;
    int unsigned  w;
    int unsigned  h;
    int unsigned  b;
    bit           first_pause;
    rkf_mode_t    m;
    pix_pattern_t pat;

    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.pixel_value <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.index      <= CFG_FILTER_MODE;
    cfg_ch.data       <= '0;
    settings_run      = 0;
    in_idle_en        = 1'b1;
    out_stall_en      = 1'b1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Sharpen on 3x3, two bands: lone bright center, then the inverse
    program_filter(MODE_SHARPEN, 3, 3, 2);
    for (int k = 0; k < 18; k++)
      send_pixel((((k % 9) == 4) ^ (k >= 9)) ? 8'hFF : 8'h00);
    wait_drained();

    // Emboss on 5x5 with bright upper-left corner: saturates low
    program_filter(MODE_EMBOSS, 5, 5, 1);
    for (int k = 0; k < 25; k++)
      send_pixel((k == 6 || k == 7 || k == 11) ? 8'hFF : 8'h00);
    wait_drained();

    // All four kernels on black and white content to hit both saturation ends
    for (int k = 0; k < 4; k++) begin
      program_filter(rkf_mode_t'(k), 6, 6, 1);
      run_frames(PAT_EXTREME, 1'b0);
    end

    // Zero sizes and zero band count fall back to one
    program_filter(MODE_GAUSS, 0, 7, 0);
    run_frames(PAT_UNIFORM, 1'b0);
    program_filter(MODE_SHARPEN, 6, 0, 1);
    run_frames(PAT_UNIFORM, 1'b0);
    // Too small for any interior pixel, and a small sharpen frame that still has one
    program_filter(MODE_GAUSS, 4, 6, 1);
    run_frames(PAT_UNIFORM, 1'b0);
    program_filter(MODE_RELIEF, 7, 4, 1);
    run_frames(PAT_UNIFORM, 1'b0);
    program_filter(MODE_SHARPEN, 4, 4, 0);
    run_frames(PAT_BITS, 1'b0);

    // Narrow the line in the middle of a frame: counters wrap past the new width
    program_filter(MODE_GAUSS, 8, 8, 1);
    for (int k = 0; k < 54; k++) send_pixel(gen_pixel(PAT_UNIFORM));
    wait_drained();
    write_reg(CFG_IMAGE_WIDTH, 5);
    cfg_ch.valid <= 1'b0;
    while (!sb.at_origin()) send_pixel(gen_pixel(PAT_UNIFORM));
    wait_drained();

    // Random settings and content; the final stretch runs without gaps or stalls
    rand_items  = 0;
    first_pause = 1'b1;
    while (rand_items < RANDOM_ITEMS) begin
      if (rand_items >= CALM_ITEMS) begin
        in_idle_en   = 1'b0;
        out_stall_en = 1'b0;
      end else begin
        in_idle_en   = ($urandom_range(0, 3) != 0);
        out_stall_en = ($urandom_range(0, 3) != 0);
      end
      m   = rkf_mode_t'($urandom_range(0, 3));
      w   = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 10);
      h   = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 8);
      b   = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 2);
      pat = pix_pattern_t'($urandom_range(0, 3));
      program_filter(m, w, h, b);
      rand_items += sb.frame_items();
      run_frames(pat, first_pause || ($urandom_range(0, 3) == 0));
      first_pause = 1'b0;
    end

    wait_drained();
    $display("Checked %0d filtered pixels from %0d input pixels over %0d filter settings",
             sb.results, sb.pixels, settings_run);
    $display("Covered all four kernels at both saturation ends, zero and tiny sizes, %s",
             "a mid-frame resize and multi-band frames");
    if (sb.errors == 0 && sb.expected_pixels.size() == 0) begin
      $display("raster_kernel_filter_top regression: pass");
    end else begin
      $display("raster_kernel_filter_top regression: fail");
    end
    $finish;
  end

endmodule
